[rtl/core/mtg_pkg.sv]
package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);

  typedef logic [31:0]       word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t TWIST_MATRIX = 32'h9908B0DF;
  localparam word_t TEMPER_B     = 32'h9D2C5680;
  localparam word_t TEMPER_C     = 32'hEFC60000;
  localparam word_t DEFAULT_SEED = 32'd5489;

  localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);
  localparam idx_t  WORDS_IDX = idx_t'(STATE_WORDS);

  function automatic word_t temper(input word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/core/mtg_ram.sv]
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/mersenne_twister_generator_top.sv]
// MT19937 pseudo-random word generator.
// Requests arrive on the req channel (req_valid, req_stall, reseed); each
// transaction returns exactly one tempered 32-bit word on the rsp channel
// (rsp_valid, rsp_stall, random_word). A transaction is taken at a rising
// edge where valid is high and stall is low.
// The seed register is written on the cfg channel (cfg_valid, cfg_ready,
// seed_value); a new seed takes effect at the next request with reseed set.
// A normal draw passes through states RD1 and TWIST before it loads the result
// register: the state lives in two mirrored synchronous RAMs, and the three
// state words of one twist are read in IDLE and RD1 before the write back.
// No new request is taken until the word of the last one is loaded.
// A request with reseed set first refills all 624 words, each word after the
// first passing through the seed multiplier in states FMUL and FWR.
// After reset the same fill runs with seed 5489, with req_stall held high;
// configuration writes are accepted meanwhile.
// While rsp_stall holds a finished word, one further request is accepted and
// processed, and its twist waits until the result register is free.
module mersenne_twister_generator_top
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        reseed,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed_value
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL0  = 3'd1;
  localparam logic [2:0] ST_FMUL   = 3'd2;
  localparam logic [2:0] ST_FWR    = 3'd3;
  localparam logic [2:0] ST_RD0    = 3'd4;
  localparam logic [2:0] ST_RD1    = 3'd5;
  localparam logic [2:0] ST_TWIST  = 3'd6;

  logic [2:0] state;
  word_t      seed;
  word_t      prev;
  word_t      prod;
  addr_t      fill_k;
  logic       pending;
  idx_t       read_index;
  logic       upper_bit;
  word_t      far_word;

  addr_t      cur_i;
  addr_t      nxt_i;
  addr_t      far_i;
  logic [ADDR_W:0] far_sum;
  word_t      a_q;
  word_t      b_q;
  addr_t      a_addr;
  addr_t      b_addr;
  logic       wr_en;
  addr_t      wr_addr;
  word_t      wr_data;
  word_t      twist_y;
  word_t      twist_w;
  word_t      fill_w;
  logic       out_free;
  logic       req_take;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && (state == ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign cur_i   = (read_index >= WORDS_IDX) ? '0 : read_index[ADDR_W-1:0];
  assign nxt_i   = (cur_i == LAST_ADDR) ? '0 : cur_i + addr_t'(1);
  assign far_sum = {1'b0, cur_i} + (ADDR_W+1)'(TWIST_OFFSET);
  assign far_i   = (far_sum >= (ADDR_W+1)'(STATE_WORDS)) ?
                   addr_t'(far_sum - (ADDR_W+1)'(STATE_WORDS)) : far_sum[ADDR_W-1:0];

  assign twist_y = {upper_bit, a_q[30:0]};
  assign twist_w = far_word ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);
  assign fill_w  = prod + word_t'(fill_k);

  always_comb begin
    a_addr  = cur_i;
    b_addr  = far_i;
    wr_en   = 1'b0;
    wr_addr = fill_k;
    wr_data = prev;
    unique case (state)
      ST_FILL0: begin
        wr_en = 1'b1;
      end
      ST_FWR: begin
        wr_en   = 1'b1;
        wr_data = fill_w;
      end
      ST_RD1: begin
        a_addr = nxt_i;
      end
      ST_TWIST: begin
        a_addr  = nxt_i;
        wr_en   = out_free;
        wr_addr = cur_i;
        wr_data = twist_w;
      end
      default: begin
      end
    endcase
  end

  mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (a_addr),
    .rd_data (a_q)
  );

  mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (b_addr),
    .rd_data (b_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL0;
      seed       <= DEFAULT_SEED;
      prev       <= DEFAULT_SEED;
      fill_k     <= '0;
      pending    <= 1'b0;
      read_index <= WORDS_IDX;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed <= seed_value;
      end
      if (rsp_valid && !rsp_stall && (state != ST_TWIST)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (reseed) begin
              state   <= ST_FILL0;
              prev    <= seed;
              fill_k  <= '0;
              pending <= 1'b1;
            end else begin
              state <= ST_RD1;
            end
          end
        end
        ST_FILL0: begin
          fill_k <= addr_t'(1);
          state  <= ST_FMUL;
        end
        ST_FMUL: begin
          prod  <= SEED_MULT * (prev ^ (prev >> 30));
          state <= ST_FWR;
        end
        ST_FWR: begin
          prev <= fill_w;
          if (fill_k == LAST_ADDR) begin
            read_index <= WORDS_IDX;
            pending    <= 1'b0;
            state      <= pending ? ST_RD0 : ST_IDLE;
          end else begin
            fill_k <= fill_k + addr_t'(1);
            state  <= ST_FMUL;
          end
        end
        ST_RD0: begin
          state <= ST_RD1;
        end
        ST_RD1: begin
          upper_bit <= a_q[31];
          far_word  <= b_q;
          state     <= ST_TWIST;
        end
        ST_TWIST: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            random_word <= temper(twist_w);
            read_index  <= idx_t'(cur_i) + idx_t'(1);
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/mt_word_checker.sv]
`timescale 1ns / 100ps

module mt_word_checker
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic        reseed,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [31:0] random_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] seed_value,
  output int          fail_count,
  output int          pending
);

  word_t       mt_state [STATE_WORDS];
  int unsigned mt_pos;
  word_t       seed_reg;
  word_t       predicted_words [$];
  word_t       want;

  function automatic void refill_state(input word_t s);
    word_t prev;
    mt_state[0] = s;
    for (int k = 1; k < STATE_WORDS; k++) begin
      prev = mt_state[k-1];
      mt_state[k] = SEED_MULT * (prev ^ (prev >> 30)) + word_t'(k);
    end
    mt_pos = STATE_WORDS;
  endfunction

  function automatic word_t temper_word(input word_t raw);
    word_t t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic word_t twist_and_temper();
    int unsigned i;
    int unsigned nxt;
    int unsigned far;
    word_t       y;
    word_t       w;
    i = (mt_pos >= STATE_WORDS) ? 0 : mt_pos;
    nxt = (i + 1) % STATE_WORDS;
    far = (i + TWIST_OFFSET) % STATE_WORDS;
    y = {mt_state[i][31], mt_state[nxt][30:0]};
    w = mt_state[far] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
    mt_state[i] = w;
    mt_pos = i + 1;
    return temper_word(w);
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t exp_word);
    $display("%0t: %s: got %08h, predicted %08h", $time, what, got, exp_word);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seed_reg = DEFAULT_SEED;
      refill_state(seed_reg);
      predicted_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_reg = seed_value;
      end
      if (rsp_valid && !rsp_stall) begin
        if (predicted_words.size() == 0) begin
          report_mismatch("word with no request outstanding", random_word, 32'h0);
        end else begin
          want = predicted_words.pop_front();
          if (random_word !== want) begin
            report_mismatch("random_word mismatch", random_word, want);
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (reseed) begin
          refill_state(seed_reg);
        end
        predicted_words.push_back(twist_and_temper());
      end
    end
    pending = predicted_words.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench
  import mtg_pkg::*;
();

  localparam int QUIET_LIMIT = 8000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        reseed = 1'b0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] random_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] seed_value = 32'h0;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  bit calm = 1'b0;
  bit gaps_on = 1'b1;

  always #1 clk = ~clk;

  mersenne_twister_generator_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .reseed      (reseed),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .random_word (random_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .seed_value  (seed_value)
  );

  mt_word_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .reseed      (reseed),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .random_word (random_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .seed_value  (seed_value),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done++;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic rs);
    if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      reseed <= 1'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    reseed <= rs;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    req_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input word_t s);
    cfg_valid <= 1'b1;
    seed_value <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int    count;
    word_t s;
    logic  rs;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Draws from the power-on fill, then a reseed with the default seed.
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    drain_and_settle();
    write_seed(32'h0000_0000);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);

    drain_and_settle();
    write_seed(32'hFFFF_FFFF);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // A new seed must leave the state alone until the next reseed.
    drain_and_settle();
    write_seed(32'h1234_5678);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_settle();
      case (ph)
        1:       s = 32'hFFFF_FFFF;
        4:       s = 32'h0000_0000;
        default: s = $urandom;
      endcase
      write_seed(s);
      calm = (ph == 5);
      gaps_on = (ph != 2);
      count = (ph == 0) ? 700 : 150;
      for (int n = 0; n < count; n++) begin
        if (n == 0) begin
          rs = 1'b1;
        end else if (ph == 0 || (ph == 2 && n < 4)) begin
          rs = 1'b0;
        end else begin
          rs = ($urandom_range(0, 63) == 0);
        end
        if (ph == 2 && n == 2) begin
          hold_reqs++;
        end
        send_request(rs);
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[mersenne_twister_generator_top.f]
rtl/core/mtg_pkg.sv
rtl/core/mtg_ram.sv
rtl/core/mersenne_twister_generator_top.sv
verif/mt_word_checker.sv
verif/testbench.sv
